FILE: src/c_subset_tokenizer_assert.svh
// assertion macros used by the tokenizer back part
`ifndef C_SUBSET_TOKENIZER_ASSERT_SVH
`define C_SUBSET_TOKENIZER_ASSERT_SVH

// a property that must hold whenever reset is released
`define CST_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// an implication that must hold at the next edge
`define CST_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/cst_pkg.sv
package cst_pkg;

    localparam int unsigned FIELD_BITS = 16;

    typedef enum logic [4:0] {
        TK_EOF     = 5'd0,
        TK_IDENT   = 5'd1,
        TK_NUMBER  = 5'd2,
        TK_STRING  = 5'd3,
        TK_INCLUDE = 5'd4,
        TK_INT     = 5'd5,
        TK_RETURN  = 5'd6,
        TK_PRINTF  = 5'd7,
        TK_LPAREN  = 5'd8,
        TK_RPAREN  = 5'd9,
        TK_LBRACE  = 5'd10,
        TK_RBRACE  = 5'd11,
        TK_SEMI    = 5'd12,
        TK_COMMA   = 5'd13,
        TK_HASH    = 5'd14,
        TK_LT      = 5'd15,
        TK_GT      = 5'd16,
        TK_UNKNOWN = 5'd17
    } token_kind_t;

    // one token as it leaves the front part
    typedef struct packed {
        token_kind_t             kind;
        logic [FIELD_BITS-1:0]   line;
        logic [FIELD_BITS-1:0]   column;
        logic [FIELD_BITS-1:0]   length;
        logic                    last;
    } token_t;

    // up to two tokens per source byte
    typedef struct packed {
        logic   two;
        token_t first;
        token_t second;
    } token_pair_t;

    // keyword character at a given position, 0 beyond its length
    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] p);
        logic [7:0] c;
        c = 8'd0;
        case (k)
            2'd0: begin
                case (p)
                    3'd0: c = 8'h69; 3'd1: c = 8'h6e; 3'd2: c = 8'h63; 3'd3: c = 8'h6c;
                    3'd4: c = 8'h75; 3'd5: c = 8'h64; 3'd6: c = 8'h65; default: c = 8'd0;
                endcase
            end
            2'd1: begin
                case (p)
                    3'd0: c = 8'h69; 3'd1: c = 8'h6e; 3'd2: c = 8'h74; default: c = 8'd0;
                endcase
            end
            2'd2: begin
                case (p)
                    3'd0: c = 8'h72; 3'd1: c = 8'h65; 3'd2: c = 8'h74; 3'd3: c = 8'h75;
                    3'd4: c = 8'h72; 3'd5: c = 8'h6e; default: c = 8'd0;
                endcase
            end
            default: begin
                case (p)
                    3'd0: c = 8'h70; 3'd1: c = 8'h72; 3'd2: c = 8'h69; 3'd3: c = 8'h6e;
                    3'd4: c = 8'h74; 3'd5: c = 8'h66; default: c = 8'd0;
                endcase
            end
        endcase
        return c;
    endfunction

    function automatic logic [2:0] kw_len(input logic [1:0] k);
        logic [2:0] l;
        case (k)
            2'd0:    l = 3'd7;
            2'd1:    l = 3'd3;
            default: l = 3'd6;
        endcase
        return l;
    endfunction

endpackage

FILE: src/cst_front.sv
// front part: runs the lexer mode machine one byte per accepted request
module cst_front #(
    parameter int unsigned POSITION_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_kind,
    input  logic [7:0]           in_char,
    output logic                 tok_valid,
    input  logic                 tok_room,
    output cst_pkg::token_pair_t tok_pair
);

    typedef enum logic [3:0] {
        M_IDLE, M_SLASH, M_COMMENT, M_IDENT, M_NUMBER, M_STRING,
        M_DIR_WS, M_DIR_NAME, M_INC_WS, M_HEADER, M_EOL
    } mode_t;

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
    localparam int unsigned FB = cst_pkg::FIELD_BITS;

    mode_t                    mode_reg, mode_next;
    logic [POSITION_BITS-1:0] line_reg, line_next, col_reg, col_next;
    logic [POSITION_BITS-1:0] sline_reg, sline_next, scol_reg, scol_next;
    logic [POSITION_BITS-1:0] run_reg, run_next;
    logic [3:0]               hits_reg, hits_next;
    logic                     dinc_reg, dinc_next, angle_reg, angle_next;

    logic                     take;
    logic                     n_emit;
    logic                     e_two;
    cst_pkg::token_t          t0, t1;
    logic [1:0]               cnt;

    assign in_ready = tok_room;
    assign take     = in_valid & in_ready;

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction
    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
    endfunction
    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'd48 && c <= 8'd57;
    endfunction
    function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
        return (v == POS_MAX) ? v : v + 1'b1;
    endfunction
    function automatic cst_pkg::token_t mk(input cst_pkg::token_kind_t k,
                                            input logic [POSITION_BITS-1:0] l,
                                            input logic [POSITION_BITS-1:0] c,
                                            input logic [POSITION_BITS-1:0] n);
        cst_pkg::token_t t;
        t.kind   = k;
        t.line   = FB'(l);
        t.column = FB'(c);
        t.length = FB'(n);
        t.last   = 1'b0;
        return t;
    endfunction

    always_comb begin
        logic [7:0] c;
        logic       idle_go;
        logic       dirname_end;
        logic [3:0] nh;
        cst_pkg::token_kind_t ik, pk;
        cst_pkg::token_t      tq [2];
        c           = in_char;
        mode_next   = mode_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        sline_next  = sline_reg;
        scol_next   = scol_reg;
        run_next    = run_reg;
        hits_next   = hits_reg;
        dinc_next   = dinc_reg;
        angle_next  = angle_reg;
        idle_go     = 1'b0;
        dirname_end = 1'b0;
        cnt         = 2'd0;
        pk          = cst_pkg::TK_UNKNOWN;
        tq[0]       = mk(cst_pkg::TK_EOF, '0, '0, '0);
        tq[1]       = tq[0];

        // keyword matching for the current name character
        nh = hits_reg;
        for (int k = 0; k < 4; k++) begin
            if (run_reg >= POSITION_BITS'(cst_pkg::kw_len(2'(k))) ||
                cst_pkg::kw_char(2'(k), run_reg[2:0]) != c)
                nh[k] = 1'b0;
        end
        ik = cst_pkg::TK_IDENT;
        for (int k = 3; k >= 0; k--) begin
            if (hits_reg[k] && run_reg == POSITION_BITS'(cst_pkg::kw_len(2'(k))))
                ik = cst_pkg::token_kind_t'(5'(4 + k));
        end

        if (!in_kind) begin
            unique case (mode_reg)
                M_SLASH: begin
                    if (c == 8'd47) mode_next = M_COMMENT;
                    else begin
                        tq[cnt[0]] = mk(cst_pkg::TK_UNKNOWN, sline_reg, scol_reg,
                                        POSITION_BITS'(1));
                        cnt = cnt + 1'b1; idle_go = 1'b1;
                    end
                end
                M_COMMENT: if (c == 8'd10) mode_next = M_IDLE;
                M_IDENT: begin
                    if (is_alpha(c) || is_digit(c) || c == 8'd95) begin
                        hits_next = nh; run_next = sat_inc(run_reg);
                    end else begin
                        tq[cnt[0]] = mk(ik, sline_reg, scol_reg, run_reg);
                        cnt = cnt + 1'b1; idle_go = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (is_digit(c)) run_next = sat_inc(run_reg);
                    else begin
                        tq[cnt[0]] = mk(cst_pkg::TK_NUMBER, sline_reg, scol_reg, run_reg);
                        cnt = cnt + 1'b1; idle_go = 1'b1;
                    end
                end
                M_STRING: begin
                    if (c == 8'd34) begin
                        tq[cnt[0]] = mk(cst_pkg::TK_STRING, sline_reg, scol_reg, run_reg);
                        cnt = cnt + 1'b1; mode_next = M_IDLE;
                    end else run_next = sat_inc(run_reg);
                end
                M_DIR_WS: begin
                    if (!is_space(c)) begin
                        if (is_alpha(c)) begin
                            // hits restart from all ones at position 0
                            mode_next = M_DIR_NAME;
                            hits_next = 4'b0000;
                            for (int k = 0; k < 4; k++)
                                hits_next[k] = (cst_pkg::kw_char(2'(k), 3'd0) == c);
                            run_next = POSITION_BITS'(1);
                        end else mode_next = M_EOL;
                    end
                end
                M_DIR_NAME: begin
                    if (is_alpha(c) || is_digit(c)) begin
                        hits_next = nh; run_next = sat_inc(run_reg);
                    end else dirname_end = 1'b1;
                end
                M_INC_WS: begin
                    if (!is_space(c)) begin
                        if (c == 8'd60 || c == 8'd34) begin
                            angle_next = (c == 8'd60); mode_next = M_HEADER;
                            run_next = '0;
                        end else mode_next = M_EOL;
                    end
                end
                M_HEADER: begin
                    if (c == (angle_reg ? 8'd62 : 8'd34)) mode_next = M_EOL;
                    else if (c == 8'd10) begin
                        tq[cnt[0]] = dinc_reg
                            ? mk(cst_pkg::TK_INCLUDE, sline_reg, scol_reg, run_reg)
                            : mk(cst_pkg::TK_HASH, sline_reg, scol_reg, POSITION_BITS'(1));
                        cnt = cnt + 1'b1; mode_next = M_IDLE;
                    end else run_next = sat_inc(run_reg);
                end
                M_EOL: begin
                    if (c == 8'd10) begin
                        tq[cnt[0]] = dinc_reg
                            ? mk(cst_pkg::TK_INCLUDE, sline_reg, scol_reg, run_reg)
                            : mk(cst_pkg::TK_HASH, sline_reg, scol_reg, POSITION_BITS'(1));
                        cnt = cnt + 1'b1; mode_next = M_IDLE;
                    end
                end
                default: idle_go = 1'b1;
            endcase

            // directive name ended: decide include, then replay this byte
            if (dirname_end) begin
                run_next = '0;
                if (hits_reg[0] && run_reg == POSITION_BITS'(7)) begin
                    dinc_next = 1'b1;
                    if (is_space(c)) mode_next = M_INC_WS;
                    else if (c == 8'd60 || c == 8'd34) begin
                        angle_next = (c == 8'd60); mode_next = M_HEADER;
                    end else mode_next = M_EOL;
                    if (c == 8'd10 && !is_space(c)) mode_next = M_EOL;
                end else begin
                    mode_next = M_EOL;
                    if (c == 8'd10) begin
                        tq[cnt[0]] = dinc_reg
                            ? mk(cst_pkg::TK_INCLUDE, sline_reg, scol_reg, '0)
                            : mk(cst_pkg::TK_HASH, sline_reg, scol_reg, POSITION_BITS'(1));
                        cnt = cnt + 1'b1; mode_next = M_IDLE;
                    end
                end
            end

            if (idle_go) begin
                mode_next = M_IDLE;
                if (!is_space(c)) begin
                    sline_next = line_reg; scol_next = col_reg;
                    run_next = '0; hits_next = 4'hf;
                    if (c == 8'd47) mode_next = M_SLASH;
                    else if (c == 8'd35) begin
                        mode_next = M_DIR_WS; dinc_next = 1'b0; angle_next = 1'b0;
                    end else if (is_alpha(c) || c == 8'd95) begin
                        mode_next = M_IDENT; run_next = POSITION_BITS'(1);
                        for (int k = 0; k < 4; k++)
                            hits_next[k] = (cst_pkg::kw_char(2'(k), 3'd0) == c);
                    end else if (is_digit(c)) begin
                        mode_next = M_NUMBER; run_next = POSITION_BITS'(1);
                    end else if (c == 8'd34) mode_next = M_STRING;
                    else begin
                        case (c)
                            8'd40:   pk = cst_pkg::TK_LPAREN;
                            8'd41:   pk = cst_pkg::TK_RPAREN;
                            8'd123:  pk = cst_pkg::TK_LBRACE;
                            8'd125:  pk = cst_pkg::TK_RBRACE;
                            8'd59:   pk = cst_pkg::TK_SEMI;
                            8'd44:   pk = cst_pkg::TK_COMMA;
                            8'd60:   pk = cst_pkg::TK_LT;
                            8'd62:   pk = cst_pkg::TK_GT;
                            default: pk = cst_pkg::TK_UNKNOWN;
                        endcase
                        tq[cnt[0]] = mk(pk, line_reg, col_reg, POSITION_BITS'(1));
                        cnt = cnt + 1'b1;
                        sline_next = sline_reg; scol_next = scol_reg;
                        run_next = run_reg; hits_next = hits_reg;
                    end
                end
            end

            if (c == 8'd10) begin
                line_next = sat_inc(line_reg); col_next = '0;
            end else col_next = sat_inc(col_reg);
        end else begin
            unique case (mode_reg)
                M_SLASH: begin
                    tq[cnt[0]] = mk(cst_pkg::TK_UNKNOWN, sline_reg, scol_reg,
                                    POSITION_BITS'(1));
                    cnt = cnt + 1'b1;
                end
                M_IDENT: begin
                    tq[cnt[0]] = mk(ik, sline_reg, scol_reg, run_reg); cnt = cnt + 1'b1;
                end
                M_NUMBER: begin
                    tq[cnt[0]] = mk(cst_pkg::TK_NUMBER, sline_reg, scol_reg, run_reg);
                    cnt = cnt + 1'b1;
                end
                M_STRING: begin
                    tq[cnt[0]] = mk(cst_pkg::TK_STRING, sline_reg, scol_reg, run_reg);
                    cnt = cnt + 1'b1;
                end
                M_DIR_NAME: begin
                    tq[cnt[0]] = (dinc_reg || (hits_reg[0] && run_reg == POSITION_BITS'(7)))
                        ? mk(cst_pkg::TK_INCLUDE, sline_reg, scol_reg, '0)
                        : mk(cst_pkg::TK_HASH, sline_reg, scol_reg, POSITION_BITS'(1));
                    cnt = cnt + 1'b1;
                end
                M_DIR_WS, M_INC_WS, M_HEADER, M_EOL: begin
                    tq[cnt[0]] = dinc_reg
                        ? mk(cst_pkg::TK_INCLUDE, sline_reg, scol_reg, run_reg)
                        : mk(cst_pkg::TK_HASH, sline_reg, scol_reg, POSITION_BITS'(1));
                    cnt = cnt + 1'b1;
                end
                default: ;
            endcase
            tq[cnt[0]] = mk(cst_pkg::TK_EOF, line_reg, col_reg, '0);
            cnt = cnt + 1'b1;
            mode_next = M_IDLE; line_next = POSITION_BITS'(1); col_next = '0;
            sline_next = '0; scol_next = '0; run_next = '0; hits_next = 4'hf;
            dinc_next = 1'b0; angle_next = 1'b0;
        end
        t0 = tq[0];
        t1 = tq[1];
    end

    assign n_emit = (cnt != 2'd0);
    assign e_two  = (cnt == 2'd2);

    always_comb begin
        tok_pair.two    = e_two;
        tok_pair.first  = t0;
        tok_pair.second = t1;
        tok_pair.first.last  = !e_two;
        tok_pair.second.last = 1'b1;
    end
    assign tok_valid = take & n_emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= M_IDLE;
            line_reg  <= POSITION_BITS'(1);
            col_reg   <= '0;
            sline_reg <= '0;
            scol_reg  <= '0;
            run_reg   <= '0;
            hits_reg  <= 4'hf;
            dinc_reg  <= 1'b0;
            angle_reg <= 1'b0;
        end else if (take) begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            sline_reg <= sline_next;
            scol_reg  <= scol_next;
            run_reg   <= run_next;
            hits_reg  <= hits_next;
            dinc_reg  <= dinc_next;
            angle_reg <= angle_next;
        end
    end

endmodule

FILE: src/cst_back.sv
// back part: token queue, splits pairs into single result requests
module cst_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 tok_valid,
    output logic                 tok_room,
    input  cst_pkg::token_pair_t tok_pair,
    output logic                 out_valid,
    input  logic                 out_ready,
    output cst_pkg::token_t      out_tok
);

    `include "c_subset_tokenizer_assert.svh"

    localparam int unsigned DEPTH = 4;

    cst_pkg::token_t mem [DEPTH];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;
    logic [1:0] nw;

    // room is signalled only while a full pair fits, which keeps the front simple
    assign tok_room  = (cnt_reg <= 3'(DEPTH - 2));
    assign out_valid = (cnt_reg != 3'd0);
    assign out_tok   = mem[rp_reg];
    assign pop       = out_valid & out_ready;
    assign nw        = tok_valid ? (tok_pair.two ? 2'd2 : 2'd1) : 2'd0;
    assign cnt_next  = cnt_reg + 3'(nw) - 3'(pop);

    always_ff @(posedge aclk) begin
        if (tok_valid) begin
            mem[wp_reg] <= tok_pair.first;
            if (tok_pair.two) mem[wp_reg + 2'd1] <= tok_pair.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_reg + nw;
            rp_reg  <= rp_reg + 2'(pop);
            cnt_reg <= cnt_next;
        end
    end

    `CST_ASSERT(a_no_overflow, aclk, aresetn, cnt_reg <= 3'(DEPTH), "token queue overflow")
    `CST_ASSERT(a_push_room, aclk, aresetn, !tok_valid || tok_room, "push without room")
    `CST_ASSERT_NEXT(a_pair_last, aclk, aresetn, tok_valid && tok_pair.two,
        mem[$past(wp_reg)].last == 1'b0, "first of pair marked last")

endmodule

FILE: src/c_subset_tokenizer.sv
// streaming tokenizer for a small c subset: one source byte (or end of source) is taken per
// cycle whenever the four-entry token queue has room for two tokens, and each byte gives zero,
// one or two tokens; a token can leave the cycle after its byte is taken, and results leave one
// per cycle from the queue, so the sustained rate is one byte per cycle while the consumer keeps
// up and bytes average no more than one token, and falls to the consumer's pace otherwise
module c_subset_tokenizer #(
    parameter int unsigned POSITION_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [7:0]  s_char_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_token_kind,
    output logic [15:0] m_token_line,
    output logic [15:0] m_token_column,
    output logic [15:0] m_text_length,
    output logic        m_last_of_run
);

    logic                 tok_valid, tok_room;
    cst_pkg::token_pair_t tok_pair;
    cst_pkg::token_t      out_tok;

    // front: mode machine and position counters
    cst_front #(.POSITION_BITS(POSITION_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready),
        .in_kind(s_kind), .in_char(s_char_code),
        .tok_valid(tok_valid), .tok_room(tok_room), .tok_pair(tok_pair)
    );

    // back: queue and result request
    cst_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .tok_valid(tok_valid), .tok_room(tok_room), .tok_pair(tok_pair),
        .out_valid(m_valid), .out_ready(m_ready), .out_tok(out_tok)
    );

    assign m_token_kind   = out_tok.kind;
    assign m_token_line   = out_tok.line;
    assign m_token_column = out_tok.column;
    assign m_text_length  = out_tok.length;
    assign m_last_of_run  = out_tok.last;

endmodule

FILE: dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned POS_MAX = 16'hFFFF;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned RANDOM_ITEMS = 900;

    // lexer modes of the predictor
    typedef enum logic [3:0] {
        LM_IDLE, LM_SLASH, LM_COMMENT, LM_IDENT, LM_NUMBER, LM_STRING,
        LM_DIR_WS, LM_DIR_NAME, LM_INC_WS, LM_HEADER, LM_EOL
    } lex_mode_t;

    localparam logic IN_CHAR = 1'b0;
    localparam logic IN_END  = 1'b1;

    typedef struct packed {
        cst_pkg::token_kind_t kind;
        logic [15:0] line;
        logic [15:0] column;
        logic [15:0] length;
        logic        last;
    } tok_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_kind;
    logic [7:0]  s_char_code;
    logic        m_valid;
    logic        m_ready;
    logic [4:0]  m_token_kind;
    logic [15:0] m_token_line;
    logic [15:0] m_token_column;
    logic [15:0] m_text_length;
    logic        m_last_of_run;

    c_subset_tokenizer DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind), .s_char_code(s_char_code),
        .m_valid(m_valid), .m_ready(m_ready), .m_token_kind(m_token_kind),
        .m_token_line(m_token_line), .m_token_column(m_token_column),
        .m_text_length(m_text_length), .m_last_of_run(m_last_of_run)
    );

    // predictor state
    lex_mode_t   mode;
    int unsigned cur_line, cur_col, tok_line, tok_col, run_len;
    logic [3:0]  kw_hits;
    logic        dir_incl, hdr_angle;

    tok_t        expected_tokens[$];
    tok_t        step_tokens[$];
    int unsigned errors = 0;
    int unsigned tokens_seen = 0;
    int unsigned requests_sent = 0;
    int unsigned cycles = 0;
    bit          idle_free = 0;   // sides stop idling while set
    bit          hold_off = 0;    // receiver long stall

    string kw_word[4] = '{"include", "int", "return", "printf"};
    cst_pkg::token_kind_t kw_tok[4] = '{cst_pkg::TK_INCLUDE, cst_pkg::TK_INT,
                                        cst_pkg::TK_RETURN, cst_pkg::TK_PRINTF};

    function automatic int unsigned sat(int unsigned v);
        return (v >= POS_MAX) ? POS_MAX : v + 1;
    endfunction

    function automatic bit blank(logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit letter(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void push_tok(cst_pkg::token_kind_t k, int unsigned ln,
                                     int unsigned col, int unsigned len);
        tok_t t;
        t.kind = k;
        t.line = ln[15:0];
        t.column = col[15:0];
        t.length = len[15:0];
        t.last = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic void lexer_reset();
        mode = LM_IDLE;
        cur_line = 1;
        cur_col = 0;
        tok_line = 0;
        tok_col = 0;
        run_len = 0;
        kw_hits = 4'hF;
        dir_incl = 0;
        hdr_angle = 0;
    endfunction

    // keyword tracking over a name being collected
    function automatic void name_char(logic [7:0] c);
        for (int k = 0; k < 4; k++)
            if (run_len >= kw_word[k].len() || kw_word[k][run_len] != c)
                kw_hits[k] = 1'b0;
        run_len = sat(run_len);
    endfunction

    function automatic void open_token(lex_mode_t m);
        mode = m;
        tok_line = cur_line;
        tok_col = cur_col;
        run_len = 0;
        kw_hits = 4'hF;
    endfunction

    function automatic cst_pkg::token_kind_t name_kind();
        for (int k = 0; k < 4; k++)
            if (kw_hits[k] && run_len == kw_word[k].len())
                return kw_tok[k];
        return cst_pkg::TK_IDENT;
    endfunction

    function automatic bit name_is_incl();
        return kw_hits[0] && run_len == 7;
    endfunction

    function automatic void close_directive();
        if (dir_incl)
            push_tok(cst_pkg::TK_INCLUDE, tok_line, tok_col, run_len);
        else
            push_tok(cst_pkg::TK_HASH, tok_line, tok_col, 1);
    endfunction

    function automatic void between_tokens(logic [7:0] c);
        cst_pkg::token_kind_t k;
        if (blank(c))
            return;
        if (c == "/") begin
            open_token(LM_SLASH);
        end else if (c == "#") begin
            open_token(LM_DIR_WS);
            dir_incl = 0;
            hdr_angle = 0;
        end else if (letter(c) || c == "_") begin
            open_token(LM_IDENT);
            name_char(c);
        end else if (digit(c)) begin
            open_token(LM_NUMBER);
            run_len = 1;
        end else if (c == 8'd34) begin
            open_token(LM_STRING);
        end else begin
            case (c)
                "(": k = cst_pkg::TK_LPAREN;
                ")": k = cst_pkg::TK_RPAREN;
                "{": k = cst_pkg::TK_LBRACE;
                "}": k = cst_pkg::TK_RBRACE;
                ";": k = cst_pkg::TK_SEMI;
                ",": k = cst_pkg::TK_COMMA;
                "<": k = cst_pkg::TK_LT;
                ">": k = cst_pkg::TK_GT;
                default: k = cst_pkg::TK_UNKNOWN;
            endcase
            push_tok(k, cur_line, cur_col, 1);
        end
    endfunction

    function automatic void lex_char(logic [7:0] c);
        bit again = 1;
        while (again) begin
            again = 0;
            case (mode)
                LM_IDLE: between_tokens(c);
                LM_SLASH: begin
                    if (c == "/") begin
                        mode = LM_COMMENT;
                    end else begin
                        push_tok(cst_pkg::TK_UNKNOWN, tok_line, tok_col, 1);
                        mode = LM_IDLE;
                        between_tokens(c);
                    end
                end
                LM_COMMENT: if (c == 8'd10) mode = LM_IDLE;
                LM_IDENT: begin
                    if (letter(c) || digit(c) || c == "_") begin
                        name_char(c);
                    end else begin
                        push_tok(name_kind(), tok_line, tok_col, run_len);
                        mode = LM_IDLE;
                        between_tokens(c);
                    end
                end
                LM_NUMBER: begin
                    if (digit(c)) begin
                        run_len = sat(run_len);
                    end else begin
                        push_tok(cst_pkg::TK_NUMBER, tok_line, tok_col, run_len);
                        mode = LM_IDLE;
                        between_tokens(c);
                    end
                end
                LM_STRING: begin
                    if (c == 8'd34) begin
                        push_tok(cst_pkg::TK_STRING, tok_line, tok_col, run_len);
                        mode = LM_IDLE;
                    end else begin
                        run_len = sat(run_len);
                    end
                end
                LM_DIR_WS: begin
                    if (!blank(c)) begin
                        if (letter(c)) begin
                            mode = LM_DIR_NAME;
                            run_len = 0;
                            kw_hits = 4'hF;
                            name_char(c);
                        end else begin
                            mode = LM_EOL;
                        end
                    end
                end
                LM_DIR_NAME: begin
                    if (letter(c) || digit(c)) begin
                        name_char(c);
                    end else begin
                        if (name_is_incl()) begin
                            dir_incl = 1;
                            mode = LM_INC_WS;
                        end else begin
                            mode = LM_EOL;
                        end
                        run_len = 0;
                        again = 1;
                    end
                end
                LM_INC_WS: begin
                    if (!blank(c)) begin
                        if (c == "<" || c == 8'd34) begin
                            hdr_angle = (c == "<");
                            mode = LM_HEADER;
                            run_len = 0;
                        end else begin
                            mode = LM_EOL;
                        end
                    end
                end
                LM_HEADER: begin
                    if (c == (hdr_angle ? 8'd62 : 8'd34)) begin
                        mode = LM_EOL;
                    end else if (c == 8'd10) begin
                        mode = LM_EOL;
                        again = 1;
                    end else begin
                        run_len = sat(run_len);
                    end
                end
                LM_EOL: begin
                    if (c == 8'd10) begin
                        close_directive();
                        mode = LM_IDLE;
                        between_tokens(c);
                    end
                end
                default: begin
                    mode = LM_IDLE;
                    between_tokens(c);
                end
            endcase
        end
        if (c == 8'd10) begin
            cur_line = sat(cur_line);
            cur_col = 0;
        end else begin
            cur_col = sat(cur_col);
        end
    endfunction

    // tokens for one accepted request, appended to the expected queue
    function automatic void predict_tokens(logic kind, logic [7:0] c);
        step_tokens.delete();
        if (kind == IN_CHAR) begin
            lex_char(c);
        end else begin
            case (mode)
                LM_SLASH:  push_tok(cst_pkg::TK_UNKNOWN, tok_line, tok_col, 1);
                LM_IDENT:  push_tok(name_kind(), tok_line, tok_col, run_len);
                LM_NUMBER: push_tok(cst_pkg::TK_NUMBER, tok_line, tok_col, run_len);
                LM_STRING: push_tok(cst_pkg::TK_STRING, tok_line, tok_col, run_len);
                LM_DIR_NAME: begin
                    if (name_is_incl()) begin
                        dir_incl = 1;
                        run_len = 0;
                    end
                    close_directive();
                end
                LM_DIR_WS, LM_INC_WS, LM_HEADER, LM_EOL: close_directive();
                default: ;
            endcase
            push_tok(cst_pkg::TK_EOF, cur_line, cur_col, 0);
            lexer_reset();
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size()-1].last = 1'b1;
        foreach (step_tokens[i])
            expected_tokens.push_back(step_tokens[i]);
    endfunction

    // clock
    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else if (hold_off)
            m_ready <= 1'b0;
        else
            m_ready <= idle_free ? 1'b1 : ($urandom_range(99) >= 27);
    end

    // result checker
    always @(posedge aclk) begin
        tok_t want;
        if (aresetn && m_valid && m_ready) begin
            tokens_seen++;
            if (expected_tokens.size() == 0) begin
                $error("token with nothing expected: kind %0d", m_token_kind);
                errors++;
            end else begin
                want = expected_tokens.pop_front();
                if (m_token_kind !== want.kind) begin
                    $error("token_kind expected %0d got %0d", want.kind, m_token_kind);
                    errors++;
                end
                if (m_token_line !== want.line) begin
                    $error("token_line expected %0d got %0d", want.line, m_token_line);
                    errors++;
                end
                if (m_token_column !== want.column) begin
                    $error("token_column expected %0d got %0d", want.column, m_token_column);
                    errors++;
                end
                if (m_text_length !== want.length) begin
                    $error("text_length expected %0d got %0d", want.length, m_text_length);
                    errors++;
                end
                if (m_last_of_run !== want.last) begin
                    $error("last_of_run expected %0d got %0d", want.last, m_last_of_run);
                    errors++;
                end
            end
        end
    end

    // one request: hold valid until accepted, predict on acceptance
    task automatic send_request(logic kind, logic [7:0] c);
        while (!idle_free && $urandom_range(99) < 27) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_char_code <= c;
        do @(posedge aclk); while (!s_ready);
        predict_tokens(kind, c);
        requests_sent++;
    endtask

    task automatic send_text(string txt);
        for (int i = 0; i < txt.len(); i++)
            send_request(IN_CHAR, txt[i]);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge aclk);
    endtask

    // well-formed fragments with random content
    function automatic string rand_name(int n);
        string s = "";
        for (int i = 0; i < n; i++)
            s = {s, string'(byte'(i == 0 ? "a" + $urandom_range(25)
                                         : ($urandom_range(3) == 0 ? "0" + $urandom_range(9)
                                                                   : "a" + $urandom_range(25))))};
        return s;
    endfunction

    function automatic string rand_fragment();
        string punct = "(){};,<>";
        case ($urandom_range(11))
            0: return kw_word[$urandom_range(3)];
            1: return rand_name($urandom_range(1, 9));
            2: return $sformatf("%0d", $urandom);
            3: return {"\"", rand_name($urandom_range(0, 6)), "\""};
            4: return {"// ", rand_name($urandom_range(0, 5)), "\n"};
            5: return {"#include ", string'(($urandom_range(1) ? "<" : "\"")),
                       rand_name($urandom_range(1, 6)), ".h",
                       string'(($urandom_range(1) ? ">" : "\"")), "\n"};
            6: return {"#", rand_name($urandom_range(1, 8)), " x\n"};
            7: return string'(punct[$urandom_range(7)]);
            8: return "\n";
            9: return " ";
            10: return "/";
            default: return "\t";
        endcase
    endfunction

    // directed rows: byte or end of source, and a hand-written token where obvious
    typedef struct {
        logic        kind;
        logic [7:0]  c;
        int          n_tok;
        tok_t        tok;
    } row_t;

    row_t rows[$];

    function automatic tok_t mk(cst_pkg::token_kind_t k, int ln, int col, int len);
        tok_t t;
        t.kind = k; t.line = 16'(ln); t.column = 16'(col); t.length = 16'(len);
        t.last = 1'b1;
        return t;
    endfunction

    initial begin
        row_t r;
        tok_t x;
        string frag;
        int    rnd;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_kind = IN_CHAR;
        s_char_code = 8'd0;
        lexer_reset();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: eof right after reset, zero and high bytes, punctuation, lone slash and open string at eof
        rows = '{
            '{IN_END,  8'h00, 1, mk(cst_pkg::TK_EOF, 1, 0, 0)},
            '{IN_CHAR, 8'h00, 1, mk(cst_pkg::TK_UNKNOWN, 1, 0, 1)},
            '{IN_CHAR, 8'hFF, 1, mk(cst_pkg::TK_UNKNOWN, 1, 1, 1)},
            '{IN_CHAR, "(",   1, mk(cst_pkg::TK_LPAREN, 1, 2, 1)},
            '{IN_CHAR, ")",   1, mk(cst_pkg::TK_RPAREN, 1, 3, 1)},
            '{IN_CHAR, "{",   1, mk(cst_pkg::TK_LBRACE, 1, 4, 1)},
            '{IN_CHAR, "}",   1, mk(cst_pkg::TK_RBRACE, 1, 5, 1)},
            '{IN_CHAR, ";",   1, mk(cst_pkg::TK_SEMI, 1, 6, 1)},
            '{IN_CHAR, ",",   1, mk(cst_pkg::TK_COMMA, 1, 7, 1)},
            '{IN_CHAR, "<",   1, mk(cst_pkg::TK_LT, 1, 8, 1)},
            '{IN_CHAR, ">",   1, mk(cst_pkg::TK_GT, 1, 9, 1)},
            '{IN_CHAR, "/",   0, x},
            '{IN_END,  8'h00, -1, x},
            '{IN_CHAR, "\"",  0, x},
            '{IN_CHAR, "\n",  0, x},
            '{IN_END,  8'h00, -1, x}
        };
        foreach (rows[i]) begin
            r = rows[i];
            send_request(r.kind, r.c);
            if (r.n_tok == 1) begin
                // replace the predicted token with the typed one
                void'(expected_tokens.pop_back());
                expected_tokens.push_back(r.tok);
            end
        end
        // keywords, numbers, comments, directives, lone slash before a byte
        send_text("int return printf include intx 0123 /x // c\n");
        send_text("#  include  <stdio.h>\n# define\n#include \"a\n#9\n");
        send_request(IN_END, 8'h00);
        send_text("#include");
        send_request(IN_END, 8'h00);
        wait_drained();

        // receiver holds off while the sender keeps offering requests
        hold_off = 1;
        fork
            begin
                repeat (300) @(posedge aclk);
                hold_off = 0;
            end
            for (int i = 0; i < 40; i++)
                send_text("(;");
        join
        wait_drained();

        // random: mostly well-formed fragments, some raw noise
        rnd = 0;
        while (rnd < RANDOM_ITEMS) begin
            idle_free = (rnd >= 400 && rnd < 550);
            if ($urandom_range(9) == 0) begin
                send_request(IN_CHAR, 8'($urandom_range(255)));
                rnd++;
            end else if ($urandom_range(60) == 0) begin
                send_request(IN_END, 8'($urandom_range(255)));
                rnd++;
            end else begin
                frag = rand_fragment();
                send_text(frag);
                rnd += frag.len();
            end
            if ($urandom_range(300) == 0)
                wait_drained();
        end
        idle_free = 0;
        send_request(IN_END, 8'h00);
        s_valid <= 1'b0;

        while (expected_tokens.size() != 0)
            @(posedge aclk);
        repeat (50) @(posedge aclk);

        $display("sent %0d requests (directed, long stall, random text), checked %0d tokens",
                 requests_sent, tokens_seen);
        if (errors == 0 && expected_tokens.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
